>>> hw/rtl/multi_slot_software_timer_table_macros.svh
// Assertion macros for the timer table.
// Used by multi_slot_software_timer_table.sv; expects clk and rst_n in scope.
`ifndef MULTI_SLOT_SOFTWARE_TIMER_TABLE_MACROS_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSST_CHECK_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSST_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/msst_pkg.sv
// Shared types and constants of the timer table.
// No dependencies; imported by msst_cell, msst_head, the top level and the testbench.
`default_nettype none

package msst_pkg;

  localparam int MSST_SLOTS       = 16;
  localparam int MSST_MAX_RESULTS = 16;
  localparam int MSST_EXP_W       = $clog2(MSST_MAX_RESULTS + 1);
  localparam logic [MSST_EXP_W-1:0] MSST_EXP_ONE = MSST_EXP_W'(1);
  localparam logic [MSST_EXP_W-1:0] MSST_EXP_MAX = MSST_EXP_W'(MSST_MAX_RESULTS);

  // operation codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_ADD     = 3'd1;
  localparam logic [2:0] MODE_DEL     = 3'd2;
  localparam logic [2:0] MODE_GET     = 3'd3;
  localparam logic [2:0] MODE_RESTART = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_EXPIRED = 3'd0;
  localparam logic [2:0] KIND_ADDED   = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_REMAIN  = 3'd4;
  localparam logic [2:0] KIND_NOEXP   = 3'd5;

  typedef struct packed {
    logic        in_use;
    logic        rep;
    logic [31:0] cnt_left;
    logic [31:0] reload_val;
    logic [31:0] owner_id;
  } entry_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        match;
    logic        found;
    logic [31:0] period;
    logic [31:0] timer_id;
    logic        rep;
  } head_cmd_t;

  typedef struct packed {
    logic expire;
    logic alive;
    logic claim;
  } head_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/msst_cell.sv
// One slot of the rotating timer ring: holds an entry, takes its neighbor's on shift.
// Depends on msst_pkg.
`default_nettype none

module msst_cell import msst_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   shift_en,
  input  wire entry_t ent_in,
  output entry_t      ent_out
);

  entry_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = shift_en ? ent_in : ent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_out = ent_r;

endmodule

`default_nettype wire

>>> hw/rtl/msst_head.sv
// Update logic at the head of the ring: applies the current operation to one entry.
// Depends on msst_pkg.
`default_nettype none

module msst_head import msst_pkg::*; (
  input  wire entry_t    ent,
  input  wire head_cmd_t cmd,
  output entry_t         ent_nxt,
  output head_stat_t     stat
);

  logic [31:0] dec;

  assign dec = ent.cnt_left - 32'd1;

  always_comb begin
    ent_nxt = ent;
    stat    = '0;
    unique case (cmd.mode)
      MODE_TICK: begin
        if (ent.in_use) begin
          if (dec == 32'd0) begin
            stat.expire = 1'b1;
            if (ent.rep) begin
              ent_nxt.cnt_left = ent.reload_val;
            end else begin
              ent_nxt = '0;
            end
          end else begin
            ent_nxt.cnt_left = dec;
          end
        end
      end
      MODE_ADD: begin
        // claim the lowest idle slot only
        if (!ent.in_use && !cmd.found) begin
          ent_nxt.in_use     = 1'b1;
          ent_nxt.rep        = cmd.rep;
          ent_nxt.cnt_left   = cmd.period;
          ent_nxt.reload_val = cmd.period;
          ent_nxt.owner_id   = cmd.timer_id;
          stat.claim         = 1'b1;
        end
      end
      MODE_DEL: begin
        if (cmd.match) begin
          ent_nxt = '0;
        end
      end
      MODE_RESTART: begin
        if (cmd.match) begin
          ent_nxt.cnt_left = ent.reload_val;
        end
      end
      default: begin
      end
    endcase
    stat.alive = ent_nxt.in_use;
  end

endmodule

`default_nettype wire

>>> hw/rtl/multi_slot_software_timer_table.sv
// Timer table top level: ring of slot cells, head update unit, sequencer, result register.
// Depends on msst_pkg, msst_cell, msst_head and the macros header.
//
//   port group  | direction | transaction
//   in_*        | in        | one command: tick, add, delete, get remaining, restart
//   out_*       | out       | one result; out_last marks the final one of a command
//
// The slot entries rotate through a ring of SLOTS cells past one head unit, one slot per
// cycle. A non-tick command takes one lap, then gives its result. A tick runs a scan lap
// to learn the final running flag, then an update lap, and then a no-expiry result when
// nothing expires; a stalled result register freezes the ring.
// Reset (rst_n, synchronous) clears all slots; in_ready is high whenever the ring is idle.
`default_nettype none
`include "multi_slot_software_timer_table_macros.svh"

module multi_slot_software_timer_table import msst_pkg::*; #(
  parameter int SLOTS = MSST_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [3:0]  in_slot,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [31:0] in_period,
  input  wire logic        in_repeat_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [3:0]       out_slot_out,
  output logic [31:0]      out_expired_id,
  output logic [31:0]      out_remaining,
  output logic             out_running,
  output logic             out_last
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] IDX_ONE  = IW'(1);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  logic                  alive_r, alive_nxt;
  logic                  running_r, running_nxt;
  logic [MSST_EXP_W-1:0] exp_tot_r, exp_tot_nxt;
  logic [MSST_EXP_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic [3:0]            claim_slot_r, claim_slot_nxt;
  logic [31:0]           rem_r, rem_nxt;

  logic [2:0]  cmd_mode_r;
  logic [3:0]  cmd_slot_r;
  logic [31:0] cmd_tid_r;
  logic [31:0] cmd_per_r;
  logic        cmd_rep_r;

  logic        out_valid_r;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [31:0] out_id_r, out_id_nxt;
  logic [31:0] out_rem_r, out_rem_nxt;
  logic        out_running_r, out_running_nxt;
  logic        out_last_r, out_last_nxt;

  entry_t     ring_q [SLOTS];
  entry_t     head_ent, head_nxt, wrap_ent;
  head_cmd_t  hcmd;
  head_stat_t hstat;

  logic          accept, is_tick, slot_ok, out_free;
  logic          want_emit, stall, shift_en, lap_end, load_out;
  logic [IW+3:0] idx_ext;
  logic [3:0]    idx4;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_tick  = (cmd_mode_r == MODE_TICK);
  assign slot_ok  = (8'(cmd_slot_r) < 8'(SLOTS));
  assign idx_ext  = {4'b0000, idx_r};
  assign idx4     = idx_ext[3:0];
  assign out_free = !out_valid_r || out_ready;

  assign head_ent = ring_q[0];

  always_comb begin
    hcmd.mode     = cmd_mode_r;
    hcmd.match    = (idx_ext == (IW + 4)'(cmd_slot_r));
    hcmd.found    = found_r;
    hcmd.period   = cmd_per_r;
    hcmd.timer_id = cmd_tid_r;
    hcmd.rep      = cmd_rep_r;
  end

  msst_head u_head (
    .ent     (head_ent),
    .cmd     (hcmd),
    .ent_nxt (head_nxt),
    .stat    (hstat)
  );

  // Hold the ring while an expiry waits for the result register.
  assign want_emit = (state_r == S_WALK) && is_tick && hstat.expire &&
                     (exp_cnt_r != exp_tot_r);
  assign stall     = want_emit && !out_free;
  assign shift_en  = (state_r == S_SCAN) || ((state_r == S_WALK) && !stall);
  assign lap_end   = shift_en && (idx_r == IDX_LAST);
  assign load_out  = (want_emit && out_free) || ((state_r == S_FIN) && out_free);

  // The scan lap passes entries back unchanged; the update lap writes the head result.
  assign wrap_ent = (state_r == S_WALK) ? head_nxt : head_ent;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    entry_t cell_in;
    if (k == SLOTS - 1) begin : g_wrap
      assign cell_in = wrap_ent;
    end else begin : g_link
      assign cell_in = ring_q[k+1];
    end
    msst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .ent_in   (cell_in),
      .ent_out  (ring_q[k])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    alive_nxt      = alive_r;
    running_nxt    = running_r;
    exp_tot_nxt    = exp_tot_r;
    exp_cnt_nxt    = exp_cnt_r;
    claim_slot_nxt = claim_slot_r;
    rem_nxt        = rem_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = (in_mode == MODE_TICK) ? S_SCAN : S_WALK;
          found_nxt   = 1'b0;
          alive_nxt   = 1'b0;
          exp_tot_nxt = '0;
          exp_cnt_nxt = '0;
          rem_nxt     = '0;
        end
      end
      S_SCAN: begin
        idx_nxt   = lap_end ? '0 : idx_r + IDX_ONE;
        alive_nxt = alive_r | hstat.alive;
        if (hstat.expire && (exp_tot_r != MSST_EXP_MAX)) begin
          exp_tot_nxt = exp_tot_r + MSST_EXP_ONE;
        end
        if (lap_end) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (shift_en) begin
          idx_nxt   = lap_end ? '0 : idx_r + IDX_ONE;
          alive_nxt = alive_r | hstat.alive;
          if (hstat.claim) begin
            found_nxt      = 1'b1;
            claim_slot_nxt = idx4;
          end
          if (hcmd.match && (cmd_mode_r == MODE_GET)) begin
            rem_nxt = head_ent.cnt_left;
          end
          if (want_emit) begin
            exp_cnt_nxt = exp_cnt_r + MSST_EXP_ONE;
          end
          if (lap_end) begin
            if (is_tick) begin
              if (exp_tot_r != '0) begin
                running_nxt = alive_nxt;
                state_nxt   = S_IDLE;
              end else begin
                state_nxt = S_FIN;
              end
            end else begin
              if ((cmd_mode_r == MODE_ADD) && found_nxt) begin
                running_nxt = 1'b1;
              end
              if ((cmd_mode_r == MODE_DEL) && slot_ok) begin
                running_nxt = alive_nxt;
              end
              state_nxt = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result fields: an expiry from the update lap, or the command's final result.
  always_comb begin
    out_kind_nxt    = KIND_EXPIRED;
    out_slot_nxt    = idx4;
    out_id_nxt      = head_ent.owner_id;
    out_rem_nxt     = '0;
    out_running_nxt = alive_r;
    out_last_nxt    = ((exp_cnt_r + MSST_EXP_ONE) == exp_tot_r);
    if (state_r == S_FIN) begin
      out_id_nxt      = '0;
      out_running_nxt = running_r;
      out_last_nxt    = 1'b1;
      out_slot_nxt    = cmd_slot_r;
      case (cmd_mode_r)
        MODE_TICK: begin
          out_kind_nxt = KIND_NOEXP;
          out_slot_nxt = 4'd0;
        end
        MODE_ADD: begin
          out_kind_nxt = found_r ? KIND_ADDED : KIND_FULL;
          out_slot_nxt = found_r ? claim_slot_r : 4'd0;
        end
        MODE_GET: begin
          out_kind_nxt = KIND_REMAIN;
          out_rem_nxt  = rem_r;
        end
        default: begin
          out_kind_nxt = KIND_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      alive_r     <= 1'b0;
      running_r   <= 1'b0;
      exp_tot_r   <= '0;
      exp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      found_r   <= found_nxt;
      alive_r   <= alive_nxt;
      running_r <= running_nxt;
      exp_tot_r <= exp_tot_nxt;
      exp_cnt_r <= exp_cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    claim_slot_r <= claim_slot_nxt;
    rem_r        <= rem_nxt;
    if (accept) begin
      cmd_mode_r <= in_mode;
      cmd_slot_r <= in_slot;
      cmd_tid_r  <= in_timer_id;
      cmd_per_r  <= in_period;
      cmd_rep_r  <= in_repeat_req;
    end
    if (load_out) begin
      out_kind_r    <= out_kind_nxt;
      out_slot_r    <= out_slot_nxt;
      out_id_r      <= out_id_nxt;
      out_rem_r     <= out_rem_nxt;
      out_running_r <= out_running_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_slot_out   = out_slot_r;
  assign out_expired_id = out_id_r;
  assign out_remaining  = out_rem_r;
  assign out_running    = out_running_r;
  assign out_last       = out_last_r;

  `MSST_CHECK_IMPL(a_idle_home, state_r == S_IDLE, idx_r == '0, "ring not aligned when idle")
  `MSST_CHECK_IMPL(a_exp_bound, 1'b1, exp_cnt_r <= exp_tot_r, "more expiries sent than counted")
  `MSST_CHECK_NEXT(a_stall_hold, stall, $stable(idx_r), "ring advanced during a stall")
  `MSST_CHECK_NEXT(a_fin_hold, (state_r == S_FIN) && out_valid_r && !out_ready, state_r == S_FIN, "final result dropped")

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for the timer table: directed and random commands, with a
// scoreboard class that predicts every expiry and command answer.
// Depends on msst_pkg and multi_slot_software_timer_table.
`default_nettype none

module tb;
  import msst_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int RANDOM_PER_PHASE = 117;
  localparam int DRAIN_CYCLES = 2 * MSST_SLOTS + 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] expired_id;
    logic [31:0] remaining;
    logic        running;
    logic        last;
  } timer_event_t;

  class timer_scoreboard;
    bit          used[MSST_SLOTS];
    logic [31:0] count_left[MSST_SLOTS];
    logic [31:0] reload[MSST_SLOTS];
    bit          repeats[MSST_SLOTS];
    logic [31:0] owner[MSST_SLOTS];
    bit          running;
    timer_event_t expected_events[$];
    int          errors;

    function new();
      for (int i = 0; i < MSST_SLOTS; i++) clear_slot(i);
      running = 1'b0;
      errors = 0;
    endfunction

    function void clear_slot(int i);
      used[i] = 1'b0;
      count_left[i] = '0;
      reload[i] = '0;
      repeats[i] = 1'b0;
      owner[i] = '0;
    endfunction

    // Drop the running flag once no slot is in use.
    function void settle_running();
      bit any_used;
      any_used = 1'b0;
      for (int i = 0; i < MSST_SLOTS; i++) any_used |= used[i];
      if (!any_used) running = 1'b0;
    endfunction

    function timer_event_t make_event(logic [2:0] kind, int slot, logic [31:0] id,
                                      logic [31:0] rem);
      timer_event_t ev;
      ev.kind = kind;
      ev.slot = slot[3:0];
      ev.expired_id = id;
      ev.remaining = rem;
      ev.running = 1'b0;
      ev.last = 1'b0;
      return ev;
    endfunction

    function void apply_command(logic [2:0] mode, logic [3:0] slot, logic [31:0] id,
                                logic [31:0] period, logic rep);
      timer_event_t batch[$];
      timer_event_t ev;
      bit any_expired;
      int found;
      int s;
      s = int'(slot);
      any_expired = 1'b0;
      found = -1;
      case (mode)
        MODE_TICK: begin
          for (int i = 0; i < MSST_SLOTS; i++) begin
            if (used[i]) begin
              count_left[i] = count_left[i] - 32'd1;
              if (count_left[i] == 32'd0) begin
                any_expired = 1'b1;
                if (batch.size() < MSST_MAX_RESULTS)
                  batch.push_back(make_event(KIND_EXPIRED, i, owner[i], '0));
                if (repeats[i]) count_left[i] = reload[i];
                else clear_slot(i);
              end
            end
          end
          if (any_expired) settle_running();
          else batch.push_back(make_event(KIND_NOEXP, 0, '0, '0));
        end
        MODE_ADD: begin
          for (int i = MSST_SLOTS - 1; i >= 0; i--) if (!used[i]) found = i;
          if (found >= 0) begin
            used[found] = 1'b1;
            count_left[found] = period;
            reload[found] = period;
            repeats[found] = rep;
            owner[found] = id;
            running = 1'b1;
            batch.push_back(make_event(KIND_ADDED, found, '0, '0));
          end else begin
            batch.push_back(make_event(KIND_FULL, 0, '0, '0));
          end
        end
        MODE_DEL: begin
          if (s < MSST_SLOTS) begin
            clear_slot(s);
            settle_running();
          end
          batch.push_back(make_event(KIND_DONE, s, '0, '0));
        end
        MODE_GET: begin
          batch.push_back(make_event(KIND_REMAIN, s, '0,
                                     (s < MSST_SLOTS) ? count_left[s] : 32'd0));
        end
        MODE_RESTART: begin
          if (s < MSST_SLOTS) count_left[s] = reload[s];
          batch.push_back(make_event(KIND_DONE, s, '0, '0));
        end
        default: batch.push_back(make_event(KIND_DONE, s, '0, '0));
      endcase
      for (int k = 0; k < batch.size(); k++) begin
        ev = batch[k];
        ev.running = running;
        ev.last = (k == batch.size() - 1);
        expected_events.push_back(ev);
      end
    endfunction

    task report(string line);
      $display("%s", line);
      errors++;
    endtask

    task check_event(timer_event_t got);
      timer_event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected result: kind %0d slot %0d id %h rem %h",
                         got.kind, got.slot, got.expired_id, got.remaining));
        return;
      end
      want = expected_events.pop_front();
      if (got !== want)
        report($sformatf({"mismatch (got/exp): kind %0d/%0d slot %0d/%0d id %h/%h ",
                          "rem %h/%h run %b/%b last %b/%b"},
                         got.kind, want.kind, got.slot, want.slot,
                         got.expired_id, want.expired_id, got.remaining, want.remaining,
                         got.running, want.running, got.last, want.last));
    endtask

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [3:0]  in_slot;
  logic [31:0] in_timer_id;
  logic [31:0] in_period;
  logic        in_repeat_req;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_kind;
  logic [3:0]  out_slot_out;
  logic [31:0] out_expired_id;
  logic [31:0] out_remaining;
  logic        out_running;
  logic        out_last;

  int send_idle = 27;
  int recv_idle = 87;
  timer_event_t got_event;
  timer_scoreboard sb = new();

  multi_slot_software_timer_table uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_slot       (in_slot),
    .in_timer_id   (in_timer_id),
    .in_period     (in_period),
    .in_repeat_req (in_repeat_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_slot_out  (out_slot_out),
    .out_expired_id(out_expired_id),
    .out_remaining (out_remaining),
    .out_running   (out_running),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: check on a handshake, then pick the next ready level.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got_event.kind = out_kind;
        got_event.slot = out_slot_out;
        got_event.expired_id = out_expired_id;
        got_event.remaining = out_remaining;
        got_event.running = out_running;
        got_event.last = out_last;
        sb.check_event(got_event);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Hold valid low for a random gap, then present one command until accepted.
  task automatic send_command(input logic [2:0] mode, input logic [3:0] slot,
                              input logic [31:0] id, input logic [31:0] period,
                              input logic rep);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_slot <= slot;
    in_timer_id <= id;
    in_period <= period;
    in_repeat_req <= rep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_command(mode, slot, id, period, rep);
  endtask

  task automatic random_command();
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [31:0] period;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 38) mode = MODE_TICK;
    else if (r < 62) mode = MODE_ADD;
    else if (r < 76) mode = MODE_DEL;
    else if (r < 87) mode = MODE_GET;
    else if (r < 96) mode = MODE_RESTART;
    else mode = MODE_UNUSED_LO + 3'($urandom_range(0, 2));
    // Adds fill the low slots first, so aim most handles there.
    slot = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 7)) : 4'($urandom);
    r = $urandom_range(0, 99);
    if (r < 84) period = $urandom_range(1, 6);
    else if (r < 87) period = 32'd0;
    else if (r < 90) period = 32'hFFFF_FFFF;
    else if (r < 95) period = $urandom_range(7, 40);
    else period = $urandom;
    send_command(mode, slot, $urandom, period, 1'($urandom));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= MODE_TICK;
    in_slot <= '0;
    in_timer_id <= '0;
    in_period <= '0;
    in_repeat_req <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: tick with no expiry, get, delete and restart on idle slots, unused mode.
    send_command(MODE_TICK, 4'd0, '0, '0, 1'b0);
    send_command(MODE_GET, 4'd15, '0, '0, 1'b0);
    send_command(MODE_DEL, 4'd0, '0, '0, 1'b0);
    send_command(MODE_RESTART, 4'd15, '0, '0, 1'b0);
    send_command(MODE_UNUSED_HI, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // Fill every slot with period one, overflow once, then expire all at once.
    for (int i = 0; i < MSST_SLOTS; i++)
      send_command(MODE_ADD, 4'(i), (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                   32'd1, 1'(i % 2));
    send_command(MODE_ADD, 4'd0, 32'h1234_5678, 32'd3, 1'b1);
    send_command(MODE_TICK, 4'd0, '0, '0, 1'b0);

    // Zero period wraps to all ones; full-range period counts down.
    send_command(MODE_ADD, 4'd0, 32'hA5A5_5A5A, 32'd0, 1'b1);
    send_command(MODE_ADD, 4'd0, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 1'b0);
    send_command(MODE_TICK, 4'd0, '0, '0, 1'b0);
    send_command(MODE_GET, 4'd0, '0, '0, 1'b0);
    send_command(MODE_GET, 4'd2, '0, '0, 1'b0);
    send_command(MODE_RESTART, 4'd2, '0, '0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle = 87;
        recv_idle = 27;
      end else if (phase == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (RANDOM_PER_PHASE) random_command();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
